// File: sv/assert_macros.svh
// Assertion macros used by the port checker of the swept box wall block.
// Depends on nothing; every property is clocked and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define SBW_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sbw checker: property failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define SBW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `SBW_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

// File: sv/sbw_pkg.sv
// Shared types and constants of the swept box wall collision block.
// Used by the top level and by its port checker; depends on nothing.
`default_nettype none

package sbw_pkg;

  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_COORD_BITS  = 24;

  localparam int SLOT_W = 5;
  localparam int TYPE_W = 3;
  localparam int IGN_W  = 4;

  // Bit positions of the ignore mask.
  localparam int IGN_NORTH = 0;
  localparam int IGN_EAST  = 1;
  localparam int IGN_SOUTH = 2;
  localparam int IGN_WEST  = 3;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e_t;

  typedef enum logic [TYPE_W-1:0] {
    KIND_RIGHT = 3'd0,
    KIND_LEFT  = 3'd1,
    KIND_FLOOR = 3'd2,
    KIND_CEIL  = 3'd3,
    KIND_EMPTY = 3'd4
  } kind_e_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SET1 = 6'b000010,
    ST_SET2 = 6'b000100,
    ST_SET3 = 6'b001000,
    ST_SCAN = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// File: sv/swept_box_wall_collision_top.sv
// Load beat: accepted back to back while idle. Query beat: setup states SET1, SET2 and
// SET3, then SCAN issues one slot per cycle from the wall memory read port (unless the
// pipe holds for a result stall), drains the compare pipe (s1, s2, s3) and sees it empty;
// FIN sends the closing beat, after which the next beat is taken. Result stalls also hold
// FIN. Reset (synchronous, active low) clears the per-slot written bits, so every slot
// reads as empty; there is no clearing pass.
`default_nettype none

module swept_box_wall_collision_top
  import sbw_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic                         in_operation,
  input  wire logic [SLOT_W-1:0]            in_slot,
  input  wire logic [TYPE_W-1:0]            in_wall_type,
  input  wire logic signed [COORD_BITS-1:0] in_cur_left,
  input  wire logic signed [COORD_BITS-1:0] in_cur_top,
  input  wire logic [COORD_BITS-2:0]        in_cur_width,
  input  wire logic [COORD_BITS-2:0]        in_cur_height,
  input  wire logic signed [COORD_BITS-1:0] in_prev_left,
  input  wire logic signed [COORD_BITS-1:0] in_prev_top,
  input  wire logic [COORD_BITS-2:0]        in_prev_width,
  input  wire logic [COORD_BITS-2:0]        in_prev_height,
  input  wire logic [IGN_W-1:0]             in_ignore_dirs,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic                         out_found,
  output      logic [SLOT_W-1:0]            out_hit_slot,
  output      logic signed [COORD_BITS:0]   out_offset_x,
  output      logic signed [COORD_BITS:0]   out_offset_y,
  output      logic signed [COORD_BITS:0]   out_center_x,
  output      logic signed [COORD_BITS:0]   out_center_y,
  output      logic                         out_last
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = COORD_BITS + 2;
  localparam int OB = COORD_BITS + 1;
  localparam int MW = TYPE_W + 2 * COORD_BITS + 2 * (COORD_BITS - 1);
  localparam logic [CW-1:0] CNT_END = CW'(TABLE_DEPTH);
  localparam logic signed [EW-1:0] SAT_HI = $signed({2'b00, {(OB-1){1'b1}}});
  localparam logic signed [EW-1:0] SAT_LO = $signed({2'b11, {(OB-1){1'b0}}});

  function automatic logic signed [EW-1:0] sx(input logic [COORD_BITS-1:0] v);
    return $signed({{(EW-COORD_BITS){v[COORD_BITS-1]}}, v});
  endfunction

  function automatic logic signed [EW-1:0] zx(input logic [COORD_BITS-2:0] v);
    return $signed({{(EW-COORD_BITS+1){1'b0}}, v});
  endfunction

  function automatic logic [OB-1:0] sat(input logic signed [EW-1:0] v);
    logic [OB-1:0] r;
    if (v > SAT_HI) begin
      r = {1'b0, {(OB-1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(OB-1){1'b0}}};
    end else begin
      r = v[OB-1:0];
    end
    return r;
  endfunction

  // Control state.
  state_t                  state_r, state_nxt;
  logic [CW-1:0]           cnt_r;
  logic                    s1_v_r, s2_v_r, s3_v_r;
  logic                    pend_v_r;
  logic                    out_v_r;
  logic [TABLE_DEPTH-1:0]  valid_r;

  // Wall memory and its read register.
  logic [MW-1:0]           mem [TABLE_DEPTH];
  logic [MW-1:0]           rd_r;
  logic                    rv_r;
  logic [IW-1:0]           s1_slot_r;

  // Query registers.
  logic signed [EW-1:0]    q_cl_r, q_ct_r, q_pl_r, q_pt_r;
  logic [COORD_BITS-2:0]   q_cw_r, q_ch_r, q_pw_r, q_ph_r;
  logic [IGN_W-1:0]        q_ign_r;
  logic signed [EW-1:0]    cr_r, cbt_r, pr_r, pb_r;
  logic [OB-1:0]           cx_r, cy_r;
  logic signed [EW-1:0]    bl_r, br_r, bt_r, bb_r;
  logic                    scan_right_r, scan_left_r, scan_floor_r, scan_ceil_r;
  logic                    bl_lt_br_r, bt_lt_bb_r;

  // Pipe stage two and three.
  kind_e_t                 s2_kind_r;
  logic signed [EW-1:0]    s2_wl_r, s2_wt_r, s2_wr_r, s2_wb_r;
  logic                    s2_nz_r, s2_wl_lt_br_r, s2_wt_lt_bb_r;
  logic [IW-1:0]           s2_slot_r;
  logic                    s3_hit_r, s3_isx_r;
  logic signed [EW-1:0]    s3_off_r;
  logic [IW-1:0]           s3_slot_r;

  // Held hit, emitted once the next hit or the end of the scan shows up.
  logic [SLOT_W-1:0]       pend_slot_r;
  logic [OB-1:0]           pend_ox_r, pend_oy_r;

  logic                    out_found_r, out_last_r;
  logic [SLOT_W-1:0]       out_slot_r;
  logic [OB-1:0]           out_ox_r, out_oy_r, out_cx_r, out_cy_r;

  logic                    in_acc, load_we, out_free, adv, adv_scan, issue, rd_en;
  logic                    scan_done, emit_mid, fin_emit;
  logic [IW-1:0]           wr_idx;
  logic [TYPE_W-1:0]       kind_in;
  logic [TYPE_W-1:0]       m_kind;
  logic [COORD_BITS-1:0]   m_left, m_top;
  logic [COORD_BITS-2:0]   m_w, m_h;
  logic                    mv_left, mv_down;
  logic                    ov3, match3, hit3, isx3;
  logic signed [EW-1:0]    cmp_a, cmp_b, op_m, op_s, off3;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_idx   = IW'(in_slot);
  assign load_we  = in_acc && (in_operation == OP_LOAD) && (int'(in_slot) < TABLE_DEPTH);
  assign kind_in  = (in_wall_type > KIND_EMPTY) ? KIND_EMPTY : in_wall_type;

  assign out_free  = !out_v_r || !out_stall;
  // The pipe holds only when a new hit must push the held one out and the
  // output register cannot take it.
  assign adv       = !(s3_v_r && s3_hit_r && pend_v_r && !out_free);
  assign adv_scan  = (state_r == ST_SCAN) && adv;
  assign issue     = (cnt_r != CNT_END);
  assign rd_en     = adv_scan && issue;
  assign scan_done = !issue && !s1_v_r && !s2_v_r && !s3_v_r;
  assign emit_mid  = adv_scan && s3_v_r && s3_hit_r && pend_v_r;
  assign fin_emit  = (state_r == ST_FIN) && out_free;

  assign {m_kind, m_left, m_top, m_w, m_h} = rd_r;

  assign mv_left = (q_cl_r < q_pl_r) && !q_ign_r[IGN_EAST];
  assign mv_down = (cbt_r > pb_r) && !q_ign_r[IGN_NORTH];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_operation == OP_QUERY)) state_nxt = ST_SET1;
      end
      ST_SET1: state_nxt = ST_SET2;
      ST_SET2: state_nxt = ST_SET3;
      ST_SET3: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Stage three: the edge of the union that touches the wall already satisfies
  // its side of the crossing test through the overlap, so one compare remains.
  always_comb begin
    ov3 = s2_nz_r && s2_wl_lt_br_r && s2_wt_lt_bb_r && bl_lt_br_r && bt_lt_bb_r
          && (bl_r < s2_wr_r) && (bt_r < s2_wb_r);
    match3 = 1'b0;
    isx3   = 1'b0;
    cmp_a  = '0;
    cmp_b  = '0;
    op_m   = '0;
    op_s   = '0;
    unique case (s2_kind_r)
      KIND_RIGHT: begin
        match3 = scan_right_r;
        isx3   = 1'b1;
        cmp_a  = q_pl_r;
        cmp_b  = s2_wr_r;
        op_m   = s2_wr_r;
        op_s   = q_cl_r;
      end
      KIND_LEFT: begin
        match3 = scan_left_r;
        isx3   = 1'b1;
        cmp_a  = s2_wl_r;
        cmp_b  = pr_r;
        op_m   = s2_wl_r;
        op_s   = cr_r;
      end
      KIND_FLOOR: begin
        match3 = scan_floor_r;
        cmp_a  = s2_wt_r;
        cmp_b  = pb_r;
        op_m   = s2_wt_r;
        op_s   = cbt_r;
      end
      KIND_CEIL: begin
        match3 = scan_ceil_r;
        cmp_a  = q_pt_r;
        cmp_b  = s2_wb_r;
        op_m   = s2_wb_r;
        op_s   = q_ct_r;
      end
      default: begin
      end
    endcase
    hit3 = ov3 && match3 && (cmp_a >= cmp_b);
    off3 = op_m - op_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      valid_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_we) valid_r[wr_idx] <= 1'b1;
      if (state_r == ST_SET3) begin
        cnt_r    <= '0;
        s1_v_r   <= 1'b0;
        s2_v_r   <= 1'b0;
        s3_v_r   <= 1'b0;
        pend_v_r <= 1'b0;
      end else if (adv_scan) begin
        if (issue) cnt_r <= cnt_r + 1'b1;
        s1_v_r <= issue;
        s2_v_r <= s1_v_r;
        s3_v_r <= s2_v_r;
        if (s3_v_r && s3_hit_r) pend_v_r <= 1'b1;
      end else if (fin_emit) begin
        pend_v_r <= 1'b0;
      end
      if (emit_mid || fin_emit) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) mem[wr_idx] <= {kind_in, in_cur_left, in_cur_top, in_cur_width, in_cur_height};
    if (rd_en) begin
      rd_r      <= mem[cnt_r[IW-1:0]];
      rv_r      <= valid_r[cnt_r[IW-1:0]];
      s1_slot_r <= cnt_r[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_operation == OP_QUERY)) begin
      q_cl_r  <= sx(in_cur_left);
      q_ct_r  <= sx(in_cur_top);
      q_pl_r  <= sx(in_prev_left);
      q_pt_r  <= sx(in_prev_top);
      q_cw_r  <= in_cur_width;
      q_ch_r  <= in_cur_height;
      q_pw_r  <= in_prev_width;
      q_ph_r  <= in_prev_height;
      q_ign_r <= in_ignore_dirs;
    end

    if (state_r == ST_SET1) begin
      cr_r  <= q_cl_r + zx(q_cw_r);
      cbt_r <= q_ct_r + zx(q_ch_r);
      pr_r  <= q_pl_r + zx(q_pw_r);
      pb_r  <= q_pt_r + zx(q_ph_r);
      cx_r  <= OB'(q_cl_r + zx(q_cw_r >> 1));
      cy_r  <= OB'(q_ct_r + zx(q_ch_r >> 1));
    end

    if (state_r == ST_SET2) begin
      bl_r         <= (q_cl_r < q_pl_r) ? q_cl_r : q_pl_r;
      br_r         <= (cr_r > pr_r) ? cr_r : pr_r;
      bt_r         <= (q_ct_r < q_pt_r) ? q_ct_r : q_pt_r;
      bb_r         <= (cbt_r > pb_r) ? cbt_r : pb_r;
      scan_right_r <= mv_left;
      scan_left_r  <= !mv_left && (cr_r > pr_r) && !q_ign_r[IGN_WEST];
      scan_floor_r <= mv_down;
      scan_ceil_r  <= !mv_down && (q_ct_r < q_pt_r) && !q_ign_r[IGN_SOUTH];
    end

    if (state_r == ST_SET3) begin
      bl_lt_br_r <= (bl_r < br_r);
      bt_lt_bb_r <= (bt_r < bb_r);
    end

    if (adv_scan) begin
      s2_kind_r     <= rv_r ? kind_e_t'(m_kind) : KIND_EMPTY;
      s2_wl_r       <= sx(m_left);
      s2_wt_r       <= sx(m_top);
      s2_wr_r       <= sx(m_left) + zx(m_w);
      s2_wb_r       <= sx(m_top) + zx(m_h);
      s2_nz_r       <= (m_w != '0) && (m_h != '0);
      s2_wl_lt_br_r <= (sx(m_left) < br_r);
      s2_wt_lt_bb_r <= (sx(m_top) < bb_r);
      s2_slot_r     <= s1_slot_r;
      s3_hit_r      <= hit3;
      s3_isx_r      <= isx3;
      s3_off_r      <= off3;
      s3_slot_r     <= s2_slot_r;
    end

    if (adv_scan && s3_v_r && s3_hit_r) begin
      pend_slot_r <= SLOT_W'(s3_slot_r);
      pend_ox_r   <= s3_isx_r ? sat(s3_off_r) : '0;
      pend_oy_r   <= s3_isx_r ? '0 : sat(s3_off_r);
    end

    if (emit_mid) begin
      out_found_r <= 1'b1;
      out_slot_r  <= pend_slot_r;
      out_ox_r    <= pend_ox_r;
      out_oy_r    <= pend_oy_r;
      out_cx_r    <= cx_r;
      out_cy_r    <= cy_r;
      out_last_r  <= 1'b0;
    end else if (fin_emit) begin
      // A scan without a hit closes with a single not-found beat.
      out_found_r <= pend_v_r;
      out_slot_r  <= pend_v_r ? pend_slot_r : '0;
      out_ox_r    <= pend_v_r ? pend_ox_r : '0;
      out_oy_r    <= pend_v_r ? pend_oy_r : '0;
      out_cx_r    <= cx_r;
      out_cy_r    <= cy_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid    = out_v_r;
  assign out_found    = out_found_r;
  assign out_hit_slot = out_slot_r;
  assign out_offset_x = $signed(out_ox_r);
  assign out_offset_y = $signed(out_oy_r);
  assign out_center_x = $signed(out_cx_r);
  assign out_center_y = $signed(out_cy_r);
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

// File: sv/sbw_checker.sv
// Port checker for the swept box wall collision top level, bound to it below.
// Depends on sbw_pkg and on the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sbw_checker
  import sbw_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         in_operation,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic                         out_found,
  input wire logic [SLOT_W-1:0]            out_hit_slot,
  input wire logic signed [COORD_BITS:0]   out_offset_x,
  input wire logic signed [COORD_BITS:0]   out_offset_y,
  input wire logic signed [COORD_BITS:0]   out_center_x,
  input wire logic signed [COORD_BITS:0]   out_center_y,
  input wire logic                         out_last
);

  // A query beat keeps the block busy for its scan.
  `SBW_ASSERT_NEXT(a_query_busy, clk, rst_n, in_valid && !in_stall && (in_operation == OP_QUERY), in_stall)

  // A not-found beat is always the only, and so the final, beat of its query.
  `SBW_ASSERT(a_miss_last, clk, rst_n, out_valid && !out_found |-> out_last)

  // A not-found beat carries a zero slot and zero push-out.
  `SBW_ASSERT(a_miss_zero, clk, rst_n, out_valid && !out_found |-> (out_hit_slot == '0) && (out_offset_x == '0) && (out_offset_y == '0))

  // A hit pushes out along one axis only.
  `SBW_ASSERT(a_one_axis, clk, rst_n, out_valid && out_found |-> (out_offset_x == '0) || (out_offset_y == '0))

  // A stalled result beat holds.
  `SBW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_found) && $stable(out_hit_slot) && $stable(out_offset_x) && $stable(out_offset_y) && $stable(out_center_x) && $stable(out_center_y) && $stable(out_last))

endmodule

bind swept_box_wall_collision_top sbw_checker #(.COORD_BITS(COORD_BITS)) u_sbw_checker (.*);

`default_nettype wire

// File: dv/swept_box_wall_collision_top_tb.sv
// Self-checking testbench for swept_box_wall_collision_top: wall table loads and
// swept box queries, with every result compared against an in-bench collision predictor.
// Depends on sbw_pkg and the top level RTL only.
`timescale 1ns / 100ps

module swept_box_wall_collision_top_tb;
  import sbw_pkg::*;

  localparam int DEPTH = DEF_TABLE_DEPTH;
  localparam int CB    = DEF_COORD_BITS;

  // A wall type code outside the defined range; the block stores it as empty.
  localparam logic [TYPE_W-1:0] KIND_BAD = 3'd7;

  typedef enum int {
    MOVE_NONE,
    MOVE_LEFT,
    MOVE_RIGHT,
    MOVE_DOWN,
    MOVE_UP
  } move_e_t;

  typedef struct {
    op_e_t                 op;
    logic [SLOT_W-1:0]     slot;
    logic [TYPE_W-1:0]     wtype;
    logic signed [CB-1:0]  cl;
    logic signed [CB-1:0]  ct;
    logic [CB-2:0]         cw;
    logic [CB-2:0]         ch;
    logic signed [CB-1:0]  pl;
    logic signed [CB-1:0]  pt;
    logic [CB-2:0]         pw;
    logic [CB-2:0]         ph;
    logic [IGN_W-1:0]      ign;
  } box_beat_t;

  typedef struct {
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic signed [CB:0]  off_x;
    logic signed [CB:0]  off_y;
    logic signed [CB:0]  ctr_x;
    logic signed [CB:0]  ctr_y;
    logic                last;
  } wall_hit_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic                 in_operation   = 1'b0;
  logic [SLOT_W-1:0]    in_slot        = '0;
  logic [TYPE_W-1:0]    in_wall_type   = '0;
  logic signed [CB-1:0] in_cur_left    = '0;
  logic signed [CB-1:0] in_cur_top     = '0;
  logic [CB-2:0]        in_cur_width   = '0;
  logic [CB-2:0]        in_cur_height  = '0;
  logic signed [CB-1:0] in_prev_left   = '0;
  logic signed [CB-1:0] in_prev_top    = '0;
  logic [CB-2:0]        in_prev_width  = '0;
  logic [CB-2:0]        in_prev_height = '0;
  logic [IGN_W-1:0]     in_ignore_dirs = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic                 out_found;
  logic [SLOT_W-1:0]    out_hit_slot;
  logic signed [CB:0]   out_offset_x;
  logic signed [CB:0]   out_offset_y;
  logic signed [CB:0]   out_center_x;
  logic signed [CB:0]   out_center_y;
  logic                 out_last;

  // Predictor copy of the wall table.
  kind_e_t tbl_kind   [DEPTH];
  longint  tbl_left   [DEPTH];
  longint  tbl_top    [DEPTH];
  longint  tbl_width  [DEPTH];
  longint  tbl_height [DEPTH];

  wall_hit_t expected_hits[$];
  int        err_count     = 0;
  bit        src_idle_en   = 1'b1;
  bit        sink_idle_en  = 1'b1;
  int        sink_hold_req = 0;

  swept_box_wall_collision_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_slot        (in_slot),
    .in_wall_type   (in_wall_type),
    .in_cur_left    (in_cur_left),
    .in_cur_top     (in_cur_top),
    .in_cur_width   (in_cur_width),
    .in_cur_height  (in_cur_height),
    .in_prev_left   (in_prev_left),
    .in_prev_top    (in_prev_top),
    .in_prev_width  (in_prev_width),
    .in_prev_height (in_prev_height),
    .in_ignore_dirs (in_ignore_dirs),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_found      (out_found),
    .out_hit_slot   (out_hit_slot),
    .out_offset_x   (out_offset_x),
    .out_offset_y   (out_offset_y),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous ceiling on the whole run, far beyond the slowest legal schedule.
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint lmin(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [CB:0] clamp_out(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) << CB) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CB:0];
  endfunction

  // Appends one expected result beat to the scoreboard.
  function automatic void queue_hit(input wall_hit_t h);
    expected_hits = {expected_hits, h};
  endfunction

  // Applies one accepted beat to the table copy, or queues the results a query causes.
  function automatic void predict_collisions(input box_beat_t b);
    longint cl, ct, cw, ch, cr, cbt, pl, pt, pr, pb;
    longint bl, bt, br, bb, cx, cy, wl, wt, wr, wb, ox, oy;
    move_e_t hdir, vdir;
    bit hit, have_pend;
    int k;
    wall_hit_t pend, r;
    cl = longint'(b.cl);
    ct = longint'(b.ct);
    cw = longint'(b.cw);
    ch = longint'(b.ch);
    if (b.op == OP_LOAD) begin
      if (b.slot < DEPTH) begin
        tbl_kind[b.slot]   = (b.wtype > KIND_EMPTY) ? KIND_EMPTY : kind_e_t'(b.wtype);
        tbl_left[b.slot]   = cl;
        tbl_top[b.slot]    = ct;
        tbl_width[b.slot]  = cw;
        tbl_height[b.slot] = ch;
      end
      return;
    end
    pl = longint'(b.pl);
    pt = longint'(b.pt);
    pr = pl + longint'(b.pw);
    pb = pt + longint'(b.ph);
    cr = cl + cw;
    cbt = ct + ch;
    bl = lmin(cl, pl);
    br = lmax(cr, pr);
    bt = lmin(ct, pt);
    bb = lmax(cbt, pb);
    cx = cl + (cw >> 1);
    cy = ct + (ch >> 1);

    hdir = MOVE_NONE;
    vdir = MOVE_NONE;
    if (cl < pl && !b.ign[IGN_EAST]) hdir = MOVE_LEFT;
    else if (cr > pr && !b.ign[IGN_WEST]) hdir = MOVE_RIGHT;
    if (cbt > pb && !b.ign[IGN_NORTH]) vdir = MOVE_DOWN;
    else if (ct < pt && !b.ign[IGN_SOUTH]) vdir = MOVE_UP;

    // A hit is held back one step so the final one can carry last.
    have_pend = 1'b0;
    for (k = 0; k < DEPTH; k++) begin
      if (tbl_kind[k] == KIND_EMPTY) continue;
      wl = tbl_left[k];
      wt = tbl_top[k];
      wr = wl + tbl_width[k];
      wb = wt + tbl_height[k];
      if (!(lmax(wl, bl) < lmin(wr, br) && lmax(wt, bt) < lmin(wb, bb))) continue;
      hit = 1'b0;
      ox = 0;
      oy = 0;
      case (tbl_kind[k])
        KIND_RIGHT: if (hdir == MOVE_LEFT && bl <= wr && pl >= wr) begin
          hit = 1'b1;
          ox = wr - cl;
        end
        KIND_LEFT: if (hdir == MOVE_RIGHT && br >= wl && pr <= wl) begin
          hit = 1'b1;
          ox = wl - cr;
        end
        KIND_FLOOR: if (vdir == MOVE_DOWN && bb >= wt && pb <= wt) begin
          hit = 1'b1;
          oy = wt - cbt;
        end
        KIND_CEIL: if (vdir == MOVE_UP && bt <= wb && pt >= wb) begin
          hit = 1'b1;
          oy = wb - ct;
        end
        default: ;
      endcase
      if (hit) begin
        if (have_pend) queue_hit(pend);
        pend.found = 1'b1;
        pend.slot  = SLOT_W'(k);
        pend.off_x = clamp_out(ox);
        pend.off_y = clamp_out(oy);
        pend.ctr_x = clamp_out(cx);
        pend.ctr_y = clamp_out(cy);
        pend.last  = 1'b0;
        have_pend = 1'b1;
      end
    end

    if (have_pend) begin
      pend.last = 1'b1;
      queue_hit(pend);
    end else begin
      r.found = 1'b0;
      r.slot  = '0;
      r.off_x = '0;
      r.off_y = '0;
      r.ctr_x = clamp_out(cx);
      r.ctr_y = clamp_out(cy);
      r.last  = 1'b1;
      queue_hit(r);
    end
  endfunction

  function automatic void check_field(string name, logic [CB:0] exp_v, logic [CB:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : hit_checker
    wall_hit_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual slot %0d found %0b",
                 $time, out_hit_slot, out_found);
        err_count++;
      end else begin
        e = expected_hits.pop_front();
        check_field("found", (CB+1)'(e.found), (CB+1)'(out_found));
        check_field("hit_slot", (CB+1)'(e.slot), (CB+1)'(out_hit_slot));
        check_field("offset_x", e.off_x, out_offset_x);
        check_field("offset_y", e.off_y, out_offset_y);
        check_field("center_x", e.ctr_x, out_center_x);
        check_field("center_y", e.ctr_y, out_center_y);
        check_field("last", (CB+1)'(e.last), (CB+1)'(out_last));
      end
    end
  end

  // Result side: a random hold before each beat, plus an occasional long hold on request.
  initial begin : result_sink
    int pause;
    forever begin
      pause = sink_idle_en ? $urandom_range(0, 3) : 0;
      if (sink_hold_req > 0) begin
        pause = pause + sink_hold_req;
        sink_hold_req = 0;
      end
      if (pause > 0) begin
        out_stall <= 1'b1;
        repeat (pause) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && sink_hold_req == 0) @(posedge clk);
    end
  end

  task automatic send_item(input box_beat_t b);
    int gap;
    in_valid       <= 1'b1;
    in_operation   <= b.op;
    in_slot        <= b.slot;
    in_wall_type   <= b.wtype;
    in_cur_left    <= b.cl;
    in_cur_top     <= b.ct;
    in_cur_width   <= b.cw;
    in_cur_height  <= b.ch;
    in_prev_left   <= b.pl;
    in_prev_top    <= b.pt;
    in_prev_width  <= b.pw;
    in_prev_height <= b.ph;
    in_ignore_dirs <= b.ign;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_collisions(b);
    gap = src_idle_en ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  function automatic int near_coord(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic box_beat_t rand_any();
    box_beat_t b;
    b.op    = $urandom_range(0, 1) ? OP_QUERY : OP_LOAD;
    b.slot  = SLOT_W'($urandom);
    b.wtype = TYPE_W'($urandom);
    b.cl    = CB'($urandom);
    b.ct    = CB'($urandom);
    b.cw    = (CB-1)'($urandom);
    b.ch    = (CB-1)'($urandom);
    b.pl    = CB'($urandom);
    b.pt    = CB'($urandom);
    b.pw    = (CB-1)'($urandom);
    b.ph    = (CB-1)'($urandom);
    b.ign   = IGN_W'($urandom);
    return b;
  endfunction

  // Walls clustered around the origin so that queries actually run into them.
  function automatic box_beat_t rand_wall();
    box_beat_t b;
    b = rand_any();
    b.op    = OP_LOAD;
    b.wtype = ($urandom_range(0, 9) == 0) ? TYPE_W'($urandom_range(KIND_EMPTY, KIND_BAD))
                                          : TYPE_W'($urandom_range(KIND_RIGHT, KIND_CEIL));
    b.cl    = CB'(near_coord(1024));
    b.ct    = CB'(near_coord(1024));
    b.cw    = ($urandom_range(0, 9) == 0) ? '0 : (CB-1)'($urandom_range(1, 600));
    b.ch    = ($urandom_range(0, 9) == 0) ? '0 : (CB-1)'($urandom_range(1, 600));
    return b;
  endfunction

  function automatic box_beat_t rand_query();
    box_beat_t b;
    b = rand_any();
    b.op  = OP_QUERY;
    b.pl  = CB'(near_coord(600));
    b.pt  = CB'(near_coord(600));
    b.pw  = (CB-1)'($urandom_range(16, 256));
    b.ph  = (CB-1)'($urandom_range(16, 256));
    b.cl  = CB'(int'(b.pl) + near_coord(160));
    b.ct  = CB'(int'(b.pt) + near_coord(160));
    b.cw  = ($urandom_range(0, 3) == 0) ? (CB-1)'($urandom_range(0, 256)) : b.pw;
    b.ch  = ($urandom_range(0, 3) == 0) ? (CB-1)'($urandom_range(0, 256)) : b.ph;
    b.ign = ($urandom_range(0, 4) < 3) ? '0 : IGN_W'($urandom);
    return b;
  endfunction

  function automatic box_beat_t wall_beat(logic [SLOT_W-1:0] s, logic [TYPE_W-1:0] k,
                                          int l, int t, int w, int h);
    box_beat_t b;
    b = rand_any();
    b.op    = OP_LOAD;
    b.slot  = s;
    b.wtype = k;
    b.cl    = CB'(l);
    b.ct    = CB'(t);
    b.cw    = (CB-1)'(w);
    b.ch    = (CB-1)'(h);
    return b;
  endfunction

  function automatic box_beat_t query_beat(int cl, int ct, int cw, int ch,
                                           int pl, int pt, int pw, int ph,
                                           logic [IGN_W-1:0] ign);
    box_beat_t b;
    b = rand_any();
    b.op  = OP_QUERY;
    b.cl  = CB'(cl);
    b.ct  = CB'(ct);
    b.cw  = (CB-1)'(cw);
    b.ch  = (CB-1)'(ch);
    b.pl  = CB'(pl);
    b.pt  = CB'(pt);
    b.pw  = (CB-1)'(pw);
    b.ph  = (CB-1)'(ph);
    b.ign = ign;
    return b;
  endfunction

  task automatic test_directed_cases();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    // Empty table at the coordinate extremes.
    send_item(query_beat(8388607, 8388607, 8388607, 8388607, -8388608, -8388608, 0, 0, '0));
    // One wall of each kind around a 100 by 100 box at the origin.
    send_item(wall_beat(0, KIND_RIGHT, -400, -200, 100, 400));
    send_item(wall_beat(31, KIND_LEFT, 300, -200, 100, 400));
    send_item(wall_beat(5, KIND_FLOOR, -200, 300, 400, 100));
    send_item(wall_beat(6, KIND_CEIL, -200, -400, 400, 100));
    send_item(query_beat(-350, 0, 100, 100, -250, 0, 100, 100, '0));
    send_item(query_beat(250, 0, 100, 100, 150, 0, 100, 100, '0));
    send_item(query_beat(0, 250, 100, 100, 0, 150, 100, 100, '0));
    send_item(query_beat(0, -350, 100, 100, 0, -250, 100, 100, '0));
    // Diagonal move into the floor and the left wall at once, then with sides ignored.
    send_item(query_beat(250, 250, 100, 100, 150, 150, 100, 100, '0));
    send_item(query_beat(250, 250, 100, 100, 150, 150, 100, 100, '1));
    send_item(query_beat(250, 250, 100, 100, 150, 150, 100, 100, 4'(1 << IGN_WEST)));
    // Moving left while widening: with east ignored the box counts as moving right.
    send_item(query_beat(140, 0, 200, 100, 150, 0, 100, 100, '0));
    send_item(query_beat(140, 0, 200, 100, 150, 0, 100, 100, 4'(1 << IGN_EAST)));
    // A right wall whose edge only touches the swept box never hits.
    send_item(wall_beat(1, KIND_RIGHT, -500, -200, 150, 400));
    send_item(query_beat(-350, 0, 100, 100, -250, 0, 100, 100, '0));
    // Out of range type empties the slot; zero width and zero height walls never hit.
    send_item(wall_beat(0, KIND_BAD, -400, -200, 100, 400));
    send_item(wall_beat(7, KIND_RIGHT, -400, -200, 0, 400));
    send_item(wall_beat(8, KIND_RIGHT, -400, -200, 100, 0));
    send_item(query_beat(-360, 0, 100, 100, -250, 0, 100, 100, '0));
    send_item(wall_beat(31, KIND_EMPTY, 300, -200, 100, 400));
    send_item(query_beat(250, 0, 100, 100, 150, 0, 100, 100, '0));
    // Push-out distances beyond the output range saturate.
    send_item(wall_beat(2, KIND_LEFT, -8388608, -100, 100, 200));
    send_item(query_beat(8388607, 0, 8388607, 10, -8388608, 0, 0, 10, '0));
    send_item(wall_beat(3, KIND_FLOOR, -100, -8388608, 200, 100));
    send_item(query_beat(0, 8388607, 10, 8388607, 0, -8388608, 10, 0, '0));
    wait_drained();
  endtask

  task automatic test_back_to_back();
    int k;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (k = 0; k < 6; k++) send_item(rand_wall());
    for (k = 0; k < 24; k++) send_item(rand_query());
    wait_drained();
  endtask

  // The result side holds off for a long stretch while queries keep coming,
  // so the block backs up and stalls its input.
  task automatic test_result_backpressure();
    int k;
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b1;
    sink_hold_req = 400;
    for (k = 0; k < 16; k++) send_item(rand_query());
    wait_drained();
  endtask

  task automatic test_random_scenes(int n_items);
    int sent;
    int n_walls;
    int n_queries;
    int k;
    sent = 0;
    while (sent < n_items) begin
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      n_walls = $urandom_range(2, 8);
      for (k = 0; k < n_walls; k++) begin
        send_item(rand_wall());
        sent++;
      end
      n_queries = $urandom_range(4, 10);
      for (k = 0; k < n_queries; k++) begin
        if ($urandom_range(0, 9) == 0) send_item(rand_any());
        else send_item(rand_query());
        sent++;
      end
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin : main
    int k;
    for (k = 0; k < DEPTH; k++) begin
      tbl_kind[k]   = KIND_EMPTY;
      tbl_left[k]   = 0;
      tbl_top[k]    = 0;
      tbl_width[k]  = 0;
      tbl_height[k] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_back_to_back();
    test_result_backpressure();
    test_random_scenes(360);

    wait_drained();
    repeat (64) @(posedge clk);
    if (err_count == 0 && expected_hits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/sbw_pkg.sv
sv/swept_box_wall_collision_top.sv
sv/sbw_checker.sv
dv/swept_box_wall_collision_top_tb.sv
